// ===== rtl/core/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted k-mer reference filter package
// Shared sizes, the operation codes and the queued item type.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int REF_DEPTH   = 4096;
  localparam int KEY_BITS    = 64;
  localparam int TAG_BITS    = 32;
  localparam int ADDR_BITS   = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(REF_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [KEY_BITS-1:0] key;
    logic                first;
    logic [TAG_BITS-1:0] tag;
  } item_t;

endpackage

// ===== rtl/core/sorted_kmer_reference_filter.sv =====
// ----------------------------------------------------------------------------
// Sorted k-mer reference filter
// Flags query k-mers that appear in a sorted reference list by a merge walk.
// ----------------------------------------------------------------------------
// Items enter on the input channel (in_valid, in_stall) and carry a function
// code: append a reference key, filter a query key, or clear the table.
// Appends and clears give no result. Each query gives one result on the
// output channel (out_valid, out_stall) with the key, the keep flag and the
// row tag. An input item is queued in a two-entry queue; the back end pops
// an append or a clear without waiting on the output. A query that reads the
// table reads one reference entry at a time, from the entry the pointer rests
// on and past each entry that it skips, because the reference memory has one
// read port with registered read data. A query that finds the references
// exhausted reads nothing. A result goes from the queue head into the result
// register, by way of the registered read data for a table-reading query. Reset
// empties the table, rewinds the pointer and drops any queued items. While
// the receiver stalls, the result register holds its value and the back end
// keeps working on appends and clears and on a query until it has a result;
// the input stalls once the queue is full.
// ----------------------------------------------------------------------------
module sorted_kmer_reference_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [63:0] kmer_key,
  input  logic        first_of_file,
  input  logic [31:0] row_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] kmer_out,
  output logic        keep,
  output logic [31:0] row_tag_out
);

  logic                         q_valid;
  logic                         q_pop;
  skf_pkg::item_t               q_item;
  logic [skf_pkg::KEY_BITS-1:0] key_out;

  skf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .kmer_key      (kmer_key),
    .first_of_file (first_of_file),
    .row_tag       (row_tag),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  skf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .key_out     (key_out),
    .keep        (keep),
    .row_tag_out (row_tag_out)
  );

  assign kmer_out = 64'(key_out);

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("Queue popped while empty.");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("Input stalled while the queue is empty.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(keep) && $stable(kmer_out))
    else $error("Stalled result was lost or changed.");

endmodule

// ===== rtl/core/skf_front.sv =====
// ----------------------------------------------------------------------------
// Sorted k-mer reference filter front end
// Accepts input items, decodes the function code and queues known items.
// ----------------------------------------------------------------------------
module skf_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   func,
  input  logic [63:0]                  kmer_key,
  input  logic                         first_of_file,
  input  logic [31:0]                  row_tag,
  output logic                         q_valid,
  output skf_pkg::item_t               q_item,
  input  logic                         q_pop
);

  skf_pkg::item_t                  entries [skf_pkg::QUEUE_DEPTH];
  logic [skf_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [skf_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [skf_pkg::QCNT_BITS-1:0]   count;
  logic                            accept;
  logic                            push;
  logic                            pop;
  logic                            known;
  skf_pkg::item_t                  item;

  always_comb begin
    case (func)
      skf_pkg::OP_APPEND: known = 1'b1;
      skf_pkg::OP_QUERY:  known = 1'b1;
      skf_pkg::OP_CLEAR:  known = 1'b1;
      default:            known = 1'b0;
    endcase
  end

  assign in_stall  = (count == skf_pkg::QCNT_BITS'(skf_pkg::QUEUE_DEPTH));
  assign accept    = in_valid && !in_stall;
  assign push      = accept && known;
  assign q_valid   = (count != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = entries[rd_ptr];

  assign item.op    = skf_pkg::op_t'(func);
  assign item.key   = kmer_key[skf_pkg::KEY_BITS-1:0];
  assign item.first = first_of_file;
  assign item.tag   = row_tag;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/skf_back.sv =====
// ----------------------------------------------------------------------------
// Sorted k-mer reference filter back end
// Holds the reference memory and walks it with the merge pointer.
// ----------------------------------------------------------------------------
module skf_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  skf_pkg::item_t               q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [skf_pkg::KEY_BITS-1:0] key_out,
  output logic                         keep,
  output logic [31:0]                  row_tag_out
);

  typedef enum logic {
    ST_IDLE,
    ST_CMP
  } state_t;

  logic [skf_pkg::KEY_BITS-1:0]  mem [skf_pkg::REF_DEPTH];
  logic [skf_pkg::KEY_BITS-1:0]  rd_data;

  state_t                        state;
  state_t                        state_next;
  logic [skf_pkg::CNT_BITS-1:0]  ptr;
  logic [skf_pkg::CNT_BITS-1:0]  ptr_next;
  logic [skf_pkg::CNT_BITS-1:0]  count;
  logic [skf_pkg::CNT_BITS-1:0]  count_next;
  logic [skf_pkg::KEY_BITS-1:0]  key;
  logic [skf_pkg::KEY_BITS-1:0]  key_next;
  logic [skf_pkg::TAG_BITS-1:0]  tag;
  logic [skf_pkg::TAG_BITS-1:0]  tag_next;

  logic [skf_pkg::CNT_BITS-1:0]  ptr_eff;
  logic [skf_pkg::CNT_BITS-1:0]  ptr_inc;
  logic                          slot_free;
  logic                          we;
  logic                          re;
  logic [skf_pkg::ADDR_BITS-1:0] raddr;
  logic                          emit;
  logic                          keep_val;

  assign ptr_eff   = q_item.first ? '0 : ptr;
  assign ptr_inc   = ptr + 1'b1;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    count_next = count;
    key_next   = key;
    tag_next   = tag;
    q_pop      = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    raddr      = ptr[skf_pkg::ADDR_BITS-1:0];
    emit       = 1'b0;
    keep_val   = 1'b1;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            skf_pkg::OP_APPEND: begin
              q_pop = 1'b1;
              if (count != skf_pkg::CNT_BITS'(skf_pkg::REF_DEPTH)) begin
                we         = 1'b1;
                count_next = count + 1'b1;
              end
            end
            skf_pkg::OP_CLEAR: begin
              q_pop      = 1'b1;
              count_next = '0;
              ptr_next   = '0;
            end
            skf_pkg::OP_QUERY: begin
              if (ptr_eff >= count) begin
                if (slot_free) begin
                  q_pop    = 1'b1;
                  emit     = 1'b1;
                  ptr_next = ptr_eff;
                  key_next = q_item.key;
                  tag_next = q_item.tag;
                end
              end else begin
                q_pop      = 1'b1;
                re         = 1'b1;
                raddr      = ptr_eff[skf_pkg::ADDR_BITS-1:0];
                ptr_next   = ptr_eff;
                key_next   = q_item.key;
                tag_next   = q_item.tag;
                state_next = ST_CMP;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_CMP: begin
        if (key > rd_data) begin
          if (ptr_inc < count) begin
            ptr_next = ptr_inc;
            re       = 1'b1;
            raddr    = ptr_inc[skf_pkg::ADDR_BITS-1:0];
          end else if (slot_free) begin
            ptr_next   = ptr_inc;
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (key == rd_data) begin
          if (slot_free) begin
            ptr_next   = ptr_inc;
            emit       = 1'b1;
            keep_val   = 1'b0;
            state_next = ST_IDLE;
          end
        end else if (slot_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[count[skf_pkg::ADDR_BITS-1:0]] <= q_item.key;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    tag <= tag_next;
    if (emit) begin
      key_out     <= key_next;
      keep        <= keep_val;
      row_tag_out <= tag_next;
    end
    if (rst) begin
      state     <= ST_IDLE;
      ptr       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      count <= count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/sv/tb_sorted_kmer_reference_filter.sv =====
// ----------------------------------------------------------------------------
// Sorted k-mer reference filter testbench
// Drives appends, clears, unused codes and mostly sorted query streams
// into the filter. A scoreboard walks its own copy of the reference table
// to predict each keep flag and checks every result transfer against it.
// Both sides idle at random in several phases; the receiver holds off once.
// ----------------------------------------------------------------------------
module tb_sorted_kmer_reference_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [1:0] FUNC_UNUSED     = 2'd3;
  localparam int       CYCLE_LIMIT     = 1000000;
  localparam int       HOLD_OFF_CYCLES = 300;
  localparam int       DRAIN_CYCLES    = 64;
  localparam int       RANDOM_ITEMS    = 1900;
  localparam int       PHASE_COUNT     = 8;

  typedef struct {
    bit [63:0] key;
    bit        kept;
    bit [31:0] tag;
  } filter_verdict_t;

  class kmer_filter_scoreboard;
    bit [63:0]       ref_store [skf_pkg::REF_DEPTH];
    int unsigned     stored;
    int unsigned     merge_pos;
    filter_verdict_t verdicts[$];
    int unsigned     error_count;

    function void note_input(bit [1:0] fn, bit [63:0] key, bit first, bit [31:0] tag);
      filter_verdict_t v;
      int unsigned     p;
      if (fn == skf_pkg::OP_APPEND) begin
        if (stored < skf_pkg::REF_DEPTH) begin
          ref_store[stored] = key;
          stored++;
        end
      end else if (fn == skf_pkg::OP_CLEAR) begin
        stored    = 0;
        merge_pos = 0;
      end else if (fn == skf_pkg::OP_QUERY) begin
        if (first) begin
          merge_pos = 0;
        end
        p = merge_pos;
        while (p < stored && key > ref_store[p]) begin
          p++;
        end
        v.kept = 1'b1;
        if (p < stored && key == ref_store[p]) begin
          p++;
          v.kept = 1'b0;
        end
        merge_pos = p;
        v.key     = key;
        v.tag     = tag;
        verdicts  = {verdicts, v};
      end
    endfunction

    function void check_result(bit [63:0] key, bit kept, bit [31:0] tag);
      filter_verdict_t v;
      if (verdicts.size() == 0) begin
        $display("%0t: result with no query pending: key %h keep %0b tag %h",
                 $time, key, kept, tag);
        error_count++;
      end else begin
        v = verdicts.pop_front();
        if (key !== v.key) begin
          $display("%0t: kmer_out expected %h actual %h", $time, v.key, key);
          error_count++;
        end
        if (kept !== v.kept) begin
          $display("%0t: keep for key %h expected %0b actual %0b", $time, v.key, v.kept, kept);
          error_count++;
        end
        if (tag !== v.tag) begin
          $display("%0t: row_tag_out expected %h actual %h", $time, v.tag, tag);
          error_count++;
        end
      end
    endfunction

    function int unsigned pending();
      return verdicts.size();
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [1:0]  func          = 2'd0;
  logic [63:0] kmer_key      = 64'd0;
  logic        first_of_file = 1'b0;
  logic [31:0] row_tag       = 32'd0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [63:0] kmer_out;
  logic        keep;
  logic [31:0] row_tag_out;

  kmer_filter_scoreboard sb = new();

  int unsigned sender_gap_pct = 0;
  int unsigned stall_pct      = 0;
  logic        hold_off_req   = 1'b0;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;
  bit [63:0]   loaded_keys[$];

  sorted_kmer_reference_filter i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .kmer_key      (kmer_key),
    .first_of_file (first_of_file),
    .row_tag       (row_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kmer_out      (kmer_out),
    .keep          (keep),
    .row_tag_out   (row_tag_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_input(func, kmer_key, first_of_file, row_tag);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(kmer_out, keep, row_tag_out);
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_stall    <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic bit [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(input bit [1:0] fn, input bit [63:0] key, input bit first,
                           input bit [31:0] tag);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= fn;
    kmer_key      <= key;
    first_of_file <= first;
    row_tag       <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fn != FUNC_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic run_directed();
    send_item(skf_pkg::OP_QUERY, 64'd0, 1'b1, 32'd0);
    send_item(skf_pkg::OP_APPEND, 64'd0, 1'b0, 32'hFFFF_FFFF);
    send_item(skf_pkg::OP_APPEND, 64'd5, 1'b1, $urandom());
    send_item(skf_pkg::OP_APPEND, 64'h8000_0000_0000_0000, 1'b0, $urandom());
    send_item(skf_pkg::OP_APPEND, {64{1'b1}}, 1'b0, $urandom());
    send_item(FUNC_UNUSED, {64{1'b1}}, 1'b1, 32'hFFFF_FFFF);
    send_item(skf_pkg::OP_QUERY, 64'd0, 1'b1, 32'hFFFF_FFFF);
    send_item(skf_pkg::OP_QUERY, 64'd3, 1'b0, $urandom());
    send_item(skf_pkg::OP_QUERY, 64'd5, 1'b0, $urandom());
    send_item(skf_pkg::OP_QUERY, 64'd5, 1'b0, $urandom());
    send_item(skf_pkg::OP_QUERY, {64{1'b1}}, 1'b0, $urandom());
    send_item(skf_pkg::OP_QUERY, {64{1'b1}}, 1'b0, 32'd0);
    send_item(skf_pkg::OP_QUERY, 64'd5, 1'b1, $urandom());
    send_item(skf_pkg::OP_QUERY, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, $urandom());
    send_item(skf_pkg::OP_QUERY, 64'd3, 1'b1, $urandom());
    send_item(skf_pkg::OP_CLEAR, {64{1'b1}}, 1'b1, 32'hFFFF_FFFF);
    send_item(skf_pkg::OP_QUERY, 64'd0, 1'b0, $urandom());
    send_item(skf_pkg::OP_APPEND, 64'd10, 1'b0, $urandom());
    send_item(skf_pkg::OP_APPEND, 64'd10, 1'b0, $urandom());
    send_item(skf_pkg::OP_QUERY, 64'd10, 1'b1, $urandom());
    send_item(skf_pkg::OP_QUERY, 64'd10, 1'b0, $urandom());
    send_item(skf_pkg::OP_QUERY, 64'd10, 1'b0, $urandom());
    send_item(skf_pkg::OP_QUERY, 64'd4, 1'b1, $urandom());
  endtask

  task automatic run_sorted_batch();
    bit [63:0]   refs[$];
    bit [63:0]   queries[$];
    bit [63:0]   k;
    int unsigned n_refs;
    int unsigned n_files;
    int unsigned n_queries;
    int unsigned pick;
    if ($urandom_range(9) != 0) begin
      send_item(skf_pkg::OP_CLEAR, rand_key(), 1'($urandom_range(1)), $urandom());
      loaded_keys.delete();
    end
    n_refs = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(24);
    for (int i = 0; i < n_refs; i++) begin
      if (refs.size() != 0 && $urandom_range(7) == 0) begin
        refs = {refs, refs[refs.size()-1]};
      end else begin
        refs = {refs, rand_key()};
      end
    end
    refs.sort();
    foreach (refs[j]) begin
      send_item(skf_pkg::OP_APPEND, refs[j], 1'($urandom_range(1)), $urandom());
      loaded_keys = {loaded_keys, refs[j]};
    end
    n_files = $urandom_range(1, 3);
    for (int f = 0; f < n_files; f++) begin
      queries.delete();
      n_queries = $urandom_range(1, 12);
      for (int i = 0; i < n_queries; i++) begin
        k = rand_key();
        if (loaded_keys.size() != 0) begin
          pick = $urandom_range(loaded_keys.size() - 1);
          case ($urandom_range(3))
            0, 1: k = loaded_keys[pick];
            2: k = $urandom_range(1) ? loaded_keys[pick] + 64'd1 : loaded_keys[pick] - 64'd1;
            default: k = rand_key();
          endcase
        end
        queries = {queries, k};
      end
      if ($urandom_range(9) != 0) begin
        queries.sort();
      end
      foreach (queries[j]) begin
        send_item(skf_pkg::OP_QUERY, queries[j], j == 0 && $urandom_range(7) != 0,
                  $urandom());
      end
    end
  endtask

  task automatic run_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      send_item(2'($urandom_range(3)), rand_key(), 1'($urandom_range(1)), $urandom());
    end
  endtask

  initial begin
    int unsigned stop_at;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      sender_gap_pct = (phase % 4 == 1 || phase % 4 == 3) ? 76 : 0;
      stall_pct      = (phase % 4 == 2) ? 76 : (phase % 4 == 3) ? 10 : 0;
      if (phase % 4 == 3) begin
        sender_gap_pct = 10;
      end
      if (phase == 0) begin
        hold_off_req <= 1'b1;
      end
      stop_at = items_sent + RANDOM_ITEMS / PHASE_COUNT;
      while (items_sent < stop_at) begin
        if ($urandom_range(99) < 80) begin
          run_sorted_batch();
        end else begin
          run_noise();
        end
      end
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/skf_pkg.sv
rtl/core/skf_front.sv
rtl/core/skf_back.sv
rtl/core/sorted_kmer_reference_filter.sv
tb/sv/tb_sorted_kmer_reference_filter.sv
